// File: sv/sdm_pkg.sv
// shared constants, codes and types for the signed division magic-number block
package sdm_pkg;

	localparam int W      = 32;
	localparam int CNT_W  = $clog2(W);
	localparam int PW     = $clog2(2 * W);

	localparam logic [W-1:0] TOP = {1'b1, {(W-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_UNRED = 2'd0,
		ST_POW2  = 2'd1,
		ST_MAGIC = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		STR_MUL = 2'd0,
		STR_ADD = 2'd1,
		STR_SUB = 2'd2
	} strategy_t;

	typedef struct packed {
		logic         go;
		logic [W-1:0] dividend;
		logic [W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic         done;
		logic [W-1:0] quotient;
		logic [W-1:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic [W-1:0] q1;
		logic [W-1:0] r1;
		logic [W-1:0] q2;
		logic [W-1:0] r2;
	} magic_t;

endpackage

// File: sv/sdm_div.sv
// restoring unsigned divider, one quotient bit per cycle
module sdm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  sdm_pkg::div_req_t req,
	output sdm_pkg::div_rsp_t rsp
);

	logic [sdm_pkg::W-1:0]     quo_q;
	logic [sdm_pkg::W-1:0]     rem_q;
	logic [sdm_pkg::W-1:0]     dvs_q;
	logic [sdm_pkg::CNT_W-1:0] cnt_q;
	logic                      run_q;
	logic                      done_q;

	logic [sdm_pkg::W:0] trial;
	logic [sdm_pkg::W:0] diff;
	logic                fits;

	always_comb begin
		trial = {rem_q, quo_q[sdm_pkg::W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				quo_q <= req.dividend;
				dvs_q <= req.divisor;
				rem_q <= '0;
			end else if (run_q) begin
				// remainder stays below the divisor, so the top bit drops out
				rem_q <= fits ? diff[sdm_pkg::W-1:0] : trial[sdm_pkg::W-1:0];
				quo_q <= {quo_q[sdm_pkg::W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sdm_pkg::CNT_W'(sdm_pkg::W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// File: sv/sdm_step.sv
// one doubling step of the magic-number search and its continue test
module sdm_step (
	input  sdm_pkg::magic_t        cur,
	input  logic [sdm_pkg::W-1:0]  anc,
	input  logic [sdm_pkg::W-1:0]  ad,
	input  logic [sdm_pkg::PW-1:0] p,
	output sdm_pkg::magic_t        nxt,
	output logic                   more
);

	logic [sdm_pkg::W-1:0]  r1s;
	logic [sdm_pkg::W-1:0]  r2s;
	logic                   ge1;
	logic                   ge2;
	logic [sdm_pkg::W-1:0]  delta;
	logic [sdm_pkg::PW-1:0] p_next;

	always_comb begin
		r1s    = {cur.r1[sdm_pkg::W-2:0], 1'b0};
		r2s    = {cur.r2[sdm_pkg::W-2:0], 1'b0};
		ge1    = r1s >= anc;
		ge2    = r2s >= ad;
		nxt.q1 = {cur.q1[sdm_pkg::W-2:0], ge1};
		nxt.r1 = ge1 ? r1s - anc : r1s;
		nxt.q2 = {cur.q2[sdm_pkg::W-2:0], ge2};
		nxt.r2 = ge2 ? r2s - ad : r2s;
		delta  = ad - nxt.r2;
		p_next = p + 1'b1;
		more   = ((nxt.q1 < delta) || ((nxt.q1 == delta) && (nxt.r1 == '0)))
			&& (p_next < sdm_pkg::PW'(2 * sdm_pkg::W - 1));
	end

endmodule

// File: sv/signed_division_magic_number.sv
// top level: classifies a signed divisor and searches its magic multiplier
//
// a divisor beat is taken at a rising edge with start high and busy low.
// one result comes back per beat: done is high for exactly one cycle and
// status, magnitude, pow2_shift, multiplier, post_shift and strategy are
// valid in that cycle (they hold until the next divisor is taken). the
// receiver cannot stall, so the result is simply presented once.
// work from the accepting edge to the done cycle:
//   zero or most negative divisor: done is set at the accepting edge
//   power-of-two magnitude: trailing zeros counted by a serial shift
//   other divisors: three serial divisions, then up to 32 doubling
//   steps, then a final state that registers the result
// the shared restoring divider makes one quotient bit per cycle and does
// most of this work. busy is high from the accepting edge until the
// result cycle (it stays low for a zero or most negative divisor), so one
// divisor is worked on at a time; a new start can be taken in the done cycle.
// reset (arst_n low) returns to idle with done low; nothing is kept
// between divisors.
module signed_division_magic_number (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] divisor,
	output logic               busy,
	output logic               done,
	output logic [1:0]         status,
	output logic [30:0]        magnitude,
	output logic [4:0]         pow2_shift,
	output logic signed [31:0] multiplier,
	output logic [4:0]         post_shift,
	output logic [1:0]         strategy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TZ,
		S_DIV_ANC,
		S_DIV_Q1,
		S_DIV_Q2,
		S_LOOP,
		S_FIN
	} state_t;

	state_t state_q;

	logic [sdm_pkg::W-1:0]     ad_q;
	logic                      neg_q;
	logic [sdm_pkg::W-1:0]     anc_q;
	logic [sdm_pkg::W-1:0]     sh_q;
	logic [sdm_pkg::CNT_W-1:0] tz_q;
	logic [sdm_pkg::PW-1:0]    p_q;
	sdm_pkg::magic_t           mag_q;
	logic                      done_q;
	logic [1:0]                status_q;
	logic [30:0]               magnitude_q;
	logic [4:0]                pow2_shift_q;
	logic [31:0]               multiplier_q;
	logic [4:0]                post_shift_q;
	logic [1:0]                strategy_q;
	logic                      div_go_q;
	logic [sdm_pkg::W-1:0]     div_dividend_q;
	logic [sdm_pkg::W-1:0]     div_divisor_q;

	sdm_pkg::div_req_t div_req;
	sdm_pkg::div_rsp_t div_rsp;
	sdm_pkg::magic_t   mag_next;
	logic              more;

	logic [sdm_pkg::W-1:0] v;
	logic [sdm_pkg::W-1:0] v_abs;
	logic                  v_unred;
	logic                  v_pow2;
	logic [sdm_pkg::W-1:0] m;
	logic [1:0]            strat;

	always_comb begin
		v       = divisor;
		v_abs   = v[sdm_pkg::W-1] ? (~v + 1'b1) : v;
		v_unred = (v == '0) || (v == sdm_pkg::TOP);
		v_pow2  = (v_abs & (v_abs - 1'b1)) == '0;
		// -(q2 + 1) is ~q2
		m       = neg_q ? ~mag_q.q2 : mag_q.q2 + 1'b1;
		if (!neg_q && m[sdm_pkg::W-1])
			strat = sdm_pkg::STR_ADD;
		else if (neg_q && !m[sdm_pkg::W-1] && (m != '0))
			strat = sdm_pkg::STR_SUB;
		else
			strat = sdm_pkg::STR_MUL;
	end

	assign div_req.go       = div_go_q;
	assign div_req.dividend = div_dividend_q;
	assign div_req.divisor  = div_divisor_q;

	sdm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sdm_step u_step (
		.cur  (mag_q),
		.anc  (anc_q),
		.ad   (ad_q),
		.p    (p_q),
		.nxt  (mag_next),
		.more (more)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						neg_q        <= v[sdm_pkg::W-1];
						ad_q         <= v_abs;
						sh_q         <= v_abs;
						tz_q         <= '0;
						status_q     <= sdm_pkg::ST_UNRED;
						magnitude_q  <= '0;
						pow2_shift_q <= '0;
						multiplier_q <= '0;
						post_shift_q <= '0;
						strategy_q   <= sdm_pkg::STR_MUL;
						if (v_unred) begin
							done_q <= 1'b1;
						end else if (v_pow2) begin
							state_q <= S_TZ;
						end else begin
							// remainder of (2^31 + neg) by the magnitude
							div_go_q       <= 1'b1;
							div_dividend_q <= sdm_pkg::TOP
								+ sdm_pkg::W'(v[sdm_pkg::W-1]);
							div_divisor_q  <= v_abs;
							state_q        <= S_DIV_ANC;
						end
					end
				end
				S_TZ: begin
					if (sh_q[0]) begin
						status_q     <= sdm_pkg::ST_POW2;
						magnitude_q  <= ad_q[30:0];
						pow2_shift_q <= tz_q;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						sh_q <= sh_q >> 1;
						tz_q <= tz_q + 1'b1;
					end
				end
				S_DIV_ANC: begin
					if (div_rsp.done) begin
						anc_q <= sdm_pkg::TOP + sdm_pkg::W'(neg_q) - 1'b1
							- div_rsp.remainder;
						div_go_q       <= 1'b1;
						div_dividend_q <= sdm_pkg::TOP;
						div_divisor_q  <= sdm_pkg::TOP + sdm_pkg::W'(neg_q) - 1'b1
							- div_rsp.remainder;
						state_q        <= S_DIV_Q1;
					end
				end
				S_DIV_Q1: begin
					if (div_rsp.done) begin
						mag_q.q1       <= div_rsp.quotient;
						mag_q.r1       <= div_rsp.remainder;
						div_go_q       <= 1'b1;
						div_dividend_q <= sdm_pkg::TOP;
						div_divisor_q  <= ad_q;
						state_q        <= S_DIV_Q2;
					end
				end
				S_DIV_Q2: begin
					if (div_rsp.done) begin
						mag_q.q2 <= div_rsp.quotient;
						mag_q.r2 <= div_rsp.remainder;
						p_q      <= sdm_pkg::PW'(sdm_pkg::W - 1);
						state_q  <= S_LOOP;
					end
				end
				S_LOOP: begin
					mag_q <= mag_next;
					p_q   <= p_q + 1'b1;
					if (!more)
						state_q <= S_FIN;
				end
				S_FIN: begin
					status_q     <= sdm_pkg::ST_MAGIC;
					magnitude_q  <= ad_q[30:0];
					multiplier_q <= m;
					post_shift_q <= 5'(p_q - sdm_pkg::PW'(sdm_pkg::W));
					strategy_q   <= strat;
					done_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = state_q != S_IDLE;
	assign done       = done_q;
	assign status     = status_q;
	assign magnitude  = magnitude_q;
	assign pow2_shift = pow2_shift_q;
	assign multiplier = multiplier_q;
	assign post_shift = post_shift_q;
	assign strategy   = strategy_q;

endmodule

// File: tb/sv/sdm_checker.sv
// checker for the magic-number block: predicts each divisor beat and compares the result
`timescale 1ns / 100ps

module sdm_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] divisor,
	input  logic               done,
	input  logic [1:0]         status,
	input  logic [30:0]        magnitude,
	input  logic [4:0]         pow2_shift,
	input  logic signed [31:0] multiplier,
	input  logic [4:0]         post_shift,
	input  logic [1:0]         strategy,
	output int                 fail_cnt,
	output int                 outstanding
);

	localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;
	localparam logic [63:0] TOP64  = {32'b0, sdm_pkg::TOP};

	typedef struct packed {
		sdm_pkg::status_t   status;
		logic [30:0]        magnitude;
		logic [4:0]         pow2_shift;
		logic signed [31:0] multiplier;
		logic [4:0]         post_shift;
		sdm_pkg::strategy_t strategy;
	} magic_res_t;

	magic_res_t pending_magic [$];

	function automatic magic_res_t derive_magic(input logic [31:0] d);
		magic_res_t  r;
		logic [63:0] v, ad, t, anc, q1, r1, q2, r2, delta, m;
		logic        neg;
		int          p;
		int          sh;
		r = '0;
		v = {32'b0, d};
		neg = d[31];
		if (v == 0 || v == TOP64)
			return r;
		ad = neg ? ((64'h1_0000_0000 - v) & MASK32) : v;
		r.magnitude = ad[30:0];
		if ((ad & (ad - 1)) == 0) begin
			sh = 0;
			while (sh < 63 && ad[sh] == 1'b0)
				sh++;
			r.status = sdm_pkg::ST_POW2;
			r.pow2_shift = sh[4:0];
			return r;
		end
		// ad is at least 3 here, so anc and ad are safe divisors
		p = 31;
		t = TOP64 + neg;
		anc = t - 1 - (t % ad);
		q1 = TOP64 / anc;
		r1 = TOP64 - q1 * anc;
		q2 = TOP64 / ad;
		r2 = TOP64 - q2 * ad;
		do begin
			p++;
			q1 = (q1 << 1) & MASK32;
			r1 = (r1 << 1) & MASK32;
			if (r1 >= anc) begin
				q1 = (q1 + 1) & MASK32;
				r1 = r1 - anc;
			end
			q2 = (q2 << 1) & MASK32;
			r2 = (r2 << 1) & MASK32;
			if (r2 >= ad) begin
				q2 = (q2 + 1) & MASK32;
				r2 = r2 - ad;
			end
			delta = (ad - r2) & MASK32;
		end while ((q1 < delta || (q1 == delta && r1 == 0)) && p < 63);
		m = (q2 + 1) & MASK32;
		if (neg)
			m = (64'd0 - m) & MASK32;
		r.status = sdm_pkg::ST_MAGIC;
		r.multiplier = m[31:0];
		r.post_shift = 5'(p - 32);
		if (!neg && m[31])
			r.strategy = sdm_pkg::STR_ADD;
		else if (neg && !m[31] && m != 0)
			r.strategy = sdm_pkg::STR_SUB;
		else
			r.strategy = sdm_pkg::STR_MUL;
		return r;
	endfunction

	initial begin
		fail_cnt = 0;
		outstanding = 0;
	end

	always @(posedge clk) begin : watch
		magic_res_t exp;
		if (arst_n) begin
			// the result of the older beat is retired before a beat taken at this edge
			if (done) begin
				if (pending_magic.size() == 0) begin
					if (fail_cnt < 10)
						$display("%0t: result with no divisor pending: status=%0d mult=%h",
							$time, status, multiplier);
					fail_cnt++;
				end else begin
					exp = pending_magic.pop_front();
					if (status !== exp.status || magnitude !== exp.magnitude ||
						pow2_shift !== exp.pow2_shift || multiplier !== exp.multiplier ||
						post_shift !== exp.post_shift || strategy !== exp.strategy) begin
						if (fail_cnt < 10) begin
							$display("%0t: mismatch exp st=%0d mag=%h p2=%0d m=%h ps=%0d str=%0d",
								$time, exp.status, exp.magnitude, exp.pow2_shift,
								exp.multiplier, exp.post_shift, exp.strategy);
							$display("%0t:          got st=%0d mag=%h p2=%0d m=%h ps=%0d str=%0d",
								$time, status, magnitude, pow2_shift,
								multiplier, post_shift, strategy);
						end
						fail_cnt++;
					end
				end
			end
			if (start && !busy)
				pending_magic.push_back(derive_magic(divisor));
			outstanding = pending_magic.size();
		end
	end

endmodule

// File: tb/sv/tb.sv
// testbench top: drives divisor beats into the magic-number block and gives the verdict
`timescale 1ns / 100ps

module tb;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic signed [31:0] divisor;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [30:0]        magnitude;
	logic [4:0]         pow2_shift;
	logic signed [31:0] multiplier;
	logic [4:0]         post_shift;
	logic [1:0]         strategy;
	int                 fail_cnt;
	int                 outstanding;

	signed_division_magic_number dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.divisor    (divisor),
		.busy       (busy),
		.done       (done),
		.status     (status),
		.magnitude  (magnitude),
		.pow2_shift (pow2_shift),
		.multiplier (multiplier),
		.post_shift (post_shift),
		.strategy   (strategy)
	);

	sdm_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.divisor     (divisor),
		.done        (done),
		.status      (status),
		.magnitude   (magnitude),
		.pow2_shift  (pow2_shift),
		.multiplier  (multiplier),
		.post_shift  (post_shift),
		.strategy    (strategy),
		.fail_cnt    (fail_cnt),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("** signed_division_magic_number: FAILED **");
		$finish;
	end

	// holds start high while busy, so the beat is taken at the first rising edge with busy low
	task automatic send_divisor(input logic [31:0] d);
		@(negedge clk);
		start <= 1'b1;
		divisor <= d;
		while (busy)
			@(negedge clk);
	endtask

	// idle burst, optionally placed after the block has gone idle
	task automatic hold_off(input int n, input bit after_idle);
		@(negedge clk);
		start <= 1'b0;
		divisor <= $urandom;
		if (after_idle)
			while (busy)
				@(negedge clk);
		repeat (n - 1)
			@(negedge clk);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	function automatic logic [31:0] pick_divisor();
		int          kind;
		int          k;
		logic [31:0] d;
		kind = $urandom_range(0, 99);
		k = $urandom_range(0, 31);
		if (kind < 30)
			d = $urandom;
		else if (kind < 55)
			d = $urandom_range(1, 1000);
		else if (kind < 70)
			d = 32'd1 << k;
		else if (kind < 85)
			d = (32'd1 << k) + $urandom_range(0, 6) - 3;
		else if (kind < 90)
			d = $urandom_range(0, 1) ? 32'h0 : sdm_pkg::TOP;
		else
			d = 32'h7FFF_FFFF - $urandom_range(0, 1000);
		if ($urandom_range(0, 1))
			d = -d;
		return d;
	endfunction

	initial begin : stimulus
		logic [31:0] directed [$];
		int          idle_pct;
		int          n_items;
		int          i;
		directed = '{32'h0, sdm_pkg::TOP, 32'd1, -32'sd1, 32'd2, -32'sd2, 32'd3, -32'sd3,
			32'd5, -32'sd5, 32'd6, -32'sd6, 32'd7, -32'sd7, 32'd641, 32'd125,
			32'h4000_0000, -32'sh4000_0000, 32'h7FFF_FFFF, 32'h8000_0001,
			32'h3FFF_FFFF, 32'hC000_0001, 32'd1000, 32'hFFFF_FC18};
		n_items = 1525;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		divisor = '0;
		repeat (11)
			@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[j]) begin
			if ($urandom_range(0, 2) == 0)
				hold_off($urandom_range(1, 11), $urandom_range(0, 1));
			send_divisor(directed[j]);
		end
		drain_results();

		for (i = 0; i < n_items; i++) begin
			// alternate stretches with and without idling, none near the end
			if (i % 100 == 0)
				idle_pct = (i / 100) % 2 ? 0 : $urandom_range(20, 60);
			if (i >= n_items - 150)
				idle_pct = 0;
			if (i % 250 == 249)
				drain_results();
			if ($urandom_range(0, 99) < idle_pct)
				hold_off($urandom_range(1, 11), $urandom_range(0, 1));
			send_divisor(pick_divisor());
		end

		@(negedge clk);
		start <= 1'b0;
		for (i = 0; i < 2000 && outstanding != 0; i++)
			@(negedge clk);
		repeat (150)
			@(negedge clk);
		if (fail_cnt == 0 && outstanding == 0)
			$display("** signed_division_magic_number: PASSED **");
		else
			$display("** signed_division_magic_number: FAILED **");
		$finish;
	end

endmodule
